FILE: sv/assert_macros.svh
// assertion macros shared by the matcher modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define LTSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true on a rising clock edge outside reset
`define LTSM_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/ltsm_pkg.sv
// types, constants and byte classifiers of the line text search matcher
package ltsm_pkg;

  localparam int MaxPattern = 16;
  localparam int WinDepth   = MaxPattern + 1;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int PatIdxW    = $clog2(MaxPattern);
  localparam int BilW       = $clog2(WinDepth + 1);
  localparam int CmdDepth   = 2;
  localparam int ResDepth   = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int LineW      = 32;

  localparam logic [7:0] CharBel   = 8'h07;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSub   = 8'h1A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_FIRST  = 3'd0,
    CFG_PAT_SECOND = 3'd1,
    CFG_PAT_LEN    = 3'd2,
    CFG_CASE_SENS  = 3'd3,
    CFG_WHOLE_WORD = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_file;
  } in_item_t;

  typedef struct packed {
    logic [LineW-1:0] line_number;
    logic             line_matched;
    logic             file_done;
    logic             binary_abort;
    logic             file_matched;
  } out_item_t;

  typedef struct packed {
    logic [63:0]     pat_first;
    logic [63:0]     pat_second;
    logic [LenW-1:0] pat_len;
    logic            case_sens;
    logic            whole_word;
  } cfg_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic [7:0] tbyte;
    logic       is_sep;
    logic       is_bin;
    logic       is_nl;
    logic       is_cr;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic case_sens);
    logic [7:0] r;
    r = b;
    if (!case_sens && b >= CharLowA && b <= CharLowZ) r = b - CharSpace;
    return r;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    logic r;
    case (b) inside
      8'h09, 8'h0A, 8'h0D, [8'h20:8'h2F], [8'h3A:8'h40], [8'h5B:8'h5E], 8'h60,
      [8'h7B:8'h7E]: r = 1'b1;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_binary(input logic [7:0] b);
    return (b < CharSpace) && ((b < CharBel) || (b > CharCr)) && (b != CharSub);
  endfunction

endpackage

FILE: sv/ltsm_front.sv
// front part: classifies each incoming text byte
module ltsm_front (
  input  ltsm_pkg::in_item_t item_i,
  input  logic               case_sens_i,
  output ltsm_pkg::cmd_t     cmd_o
);
  import ltsm_pkg::*;

  always_comb begin
    cmd_o.tbyte  = fold(item_i.text_byte, case_sens_i);
    cmd_o.is_sep = is_sep(item_i.text_byte);
    cmd_o.is_bin = is_binary(item_i.text_byte);
    cmd_o.is_nl  = (item_i.text_byte == CharLf);
    cmd_o.is_cr  = (item_i.text_byte == CharCr);
    cmd_o.last   = item_i.last_of_file;
  end

endmodule

FILE: sv/ltsm_cmd_queue.sv
// two entry queue of classified requests between front and back
`include "assert_macros.svh"

module ltsm_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ltsm_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output ltsm_pkg::cmd_t cmd_o,
  input  logic           pop_i
);
  import ltsm_pkg::*;

  localparam int PtrW = $clog2(CmdDepth);
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrW'(CmdDepth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  `LTSM_ASSERT(a_cnt_bound, cnt_q <= CntW'(CmdDepth), "request queue count out of range")
  `LTSM_ASSERT(a_ptr_gap, (wr_q - rd_q) == cnt_q[PtrW-1:0], "request queue pointers disagree")

endmodule

FILE: sv/ltsm_back.sv
// back part: sliding window compare, line and file bookkeeping, result queue
`include "assert_macros.svh"

module ltsm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ltsm_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  ltsm_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_empty_o,
  input  logic                res_pop_i,
  output ltsm_pkg::out_item_t res_o
);
  import ltsm_pkg::*;

  localparam int RPtrW = $clog2(ResDepth);
  localparam int RCntW = $clog2(ResDepth + 1);

  // window: index 0 is the newest kept byte of the line
  logic [7:0]         win_byte_q [MaxPattern];
  logic [WinDepth-1:0] win_sep_q;
  logic [7:0]         nb [MaxPattern];
  logic [WinDepth-1:0] ns;
  logic [7:0]         pat_fold [MaxPattern];
  logic [7:0]         apat [MaxPattern];
  logic [LenW-1:0]    len, idx_tmp;

  logic [BilW-1:0]    bil_q, bil_d, bil_inc;
  logic [PatIdxW-1:0] skip_q, skip_d, skip_t;
  logic               pend_q, pend_d, pend_t;
  logic               lhit_q, lhit_d, lhit_t;
  logic               fhit_q, fhit_d;
  logic [LineW-1:0]   line_q, line_d;
  logic               abort_q, abort_d;

  logic               take, shift_en, eq_all, hit, edge_ok, matched, line_end;
  logic               res_push, res_pop;
  out_item_t          res_d;
  out_item_t          res_mem_q [ResDepth];
  logic [RPtrW-1:0]   res_wr_q, res_rd_q;
  logic [RCntW-1:0]   res_cnt_q;

  assign res_empty_o = (res_cnt_q == '0);
  assign res_o       = res_mem_q[res_rd_q];
  assign res_pop     = res_pop_i && !res_empty_o;
  assign take        = cmd_valid_i && (res_cnt_q != RCntW'(ResDepth));
  assign cmd_pop_o   = take;

  assign len = (cfg_i.pat_len > LenW'(MaxPattern)) ? LenW'(MaxPattern) : cfg_i.pat_len;

  // pattern folded, then aligned to window positions
  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      if (k < 8) pat_fold[k] = fold(cfg_i.pat_first[8*k +: 8], cfg_i.case_sens);
      else       pat_fold[k] = fold(cfg_i.pat_second[8*(k-8) +: 8], cfg_i.case_sens);
    end
    for (int j = 0; j < MaxPattern; j++) begin
      idx_tmp = len - LenW'(j) - LenW'(1);
      apat[j] = pat_fold[idx_tmp[PatIdxW-1:0]];
    end
  end

  // window after the current byte would be shifted in
  always_comb begin
    nb[0] = cmd_i.tbyte;
    for (int j = 1; j < MaxPattern; j++) nb[j] = win_byte_q[j-1];
    ns = {win_sep_q[WinDepth-2:0], cmd_i.is_sep};
  end

  always_comb begin
    bil_inc = (bil_q == BilW'(WinDepth)) ? bil_q : bil_q + 1'b1;
    eq_all  = 1'b1;
    for (int j = 0; j < MaxPattern; j++) begin
      if ((LenW'(j) < len) && (nb[j] != apat[j])) eq_all = 1'b0;
    end
    hit     = (len != '0) && (skip_q == '0) && (bil_inc >= BilW'(len)) && eq_all;
    edge_ok = (bil_inc == BilW'(len)) || ns[len];

    // byte inside the line
    lhit_t = lhit_q || (pend_q && cmd_i.is_sep);
    pend_t = 1'b0;
    skip_t = skip_q;
    if ((len != '0) && (skip_q != '0)) skip_t = skip_q - 1'b1;
    if (hit) begin
      skip_t = PatIdxW'(len - LenW'(1));
      if (!cfg_i.whole_word) lhit_t = 1'b1;
      else if (edge_ok)      pend_t = 1'b1;
    end
  end

  always_comb begin
    bil_d    = bil_q;
    skip_d   = skip_q;
    pend_d   = pend_q;
    lhit_d   = lhit_q;
    fhit_d   = fhit_q;
    line_d   = line_q;
    abort_d  = abort_q;
    res_push = 1'b0;
    res_d    = '0;
    shift_en = 1'b0;
    matched  = 1'b0;
    line_end = cmd_i.is_nl || cmd_i.last;
    if (take) begin
      if (abort_q) begin
        if (cmd_i.last) begin
          bil_d   = '0;
          skip_d  = '0;
          pend_d  = 1'b0;
          lhit_d  = 1'b0;
          fhit_d  = 1'b0;
          line_d  = LineW'(1);
          abort_d = 1'b0;
        end
      end else if (cmd_i.is_bin) begin
        res_push           = 1'b1;
        res_d.line_number  = line_q;
        res_d.file_done    = 1'b1;
        res_d.binary_abort = 1'b1;
        res_d.file_matched = fhit_q;
        bil_d  = '0;
        skip_d = '0;
        pend_d = 1'b0;
        lhit_d = 1'b0;
        if (cmd_i.last) begin
          fhit_d = 1'b0;
          line_d = LineW'(1);
        end else begin
          abort_d = 1'b1;
        end
      end else begin
        if (!cmd_i.is_nl && !cmd_i.is_cr) begin
          shift_en = 1'b1;
          bil_d    = bil_inc;
          skip_d   = skip_t;
          pend_d   = pend_t;
          lhit_d   = lhit_t;
        end
        if (line_end) begin
          // a pending candidate passes at the line edge
          matched = lhit_d || pend_d;
          bil_d   = '0;
          skip_d  = '0;
          pend_d  = 1'b0;
          lhit_d  = 1'b0;
          if (cmd_i.last) begin
            res_push           = 1'b1;
            res_d.line_number  = line_q;
            res_d.line_matched = matched;
            res_d.file_done    = 1'b1;
            res_d.file_matched = fhit_q || matched;
            fhit_d             = 1'b0;
            line_d             = LineW'(1);
          end else begin
            res_push           = matched;
            res_d.line_number  = line_q;
            res_d.line_matched = 1'b1;
            res_d.file_matched = 1'b1;
            fhit_d             = fhit_q || matched;
            if (line_q != '1) line_d = line_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bil_q   <= '0;
      skip_q  <= '0;
      pend_q  <= 1'b0;
      lhit_q  <= 1'b0;
      fhit_q  <= 1'b0;
      line_q  <= LineW'(1);
      abort_q <= 1'b0;
    end else begin
      bil_q   <= bil_d;
      skip_q  <= skip_d;
      pend_q  <= pend_d;
      lhit_q  <= lhit_d;
      fhit_q  <= fhit_d;
      line_q  <= line_d;
      abort_q <= abort_d;
    end
  end

  // window payload, only positions below the fill count are ever used
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int j = 0; j < MaxPattern; j++) win_byte_q[j] <= nb[j];
      win_sep_q <= ns;
    end
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) res_wr_q <= (res_wr_q == RPtrW'(ResDepth - 1)) ? '0 : res_wr_q + 1'b1;
      if (res_pop)  res_rd_q <= (res_rd_q == RPtrW'(ResDepth - 1)) ? '0 : res_rd_q + 1'b1;
      if (res_push && !res_pop)      res_cnt_q <= res_cnt_q + 1'b1;
      else if (res_pop && !res_push) res_cnt_q <= res_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_mem_q[res_wr_q] <= res_d;
  end

  `LTSM_ASSERT(a_skip_range, skip_q <= PatIdxW'(MaxPattern - 1), "skip count out of range")
  `LTSM_ASSERT(a_abort_clean, abort_q |-> (!lhit_q && !pend_q), "line state live after abort")
  `LTSM_NEVER(a_res_overflow, res_push && (res_cnt_q == RCntW'(ResDepth)), "result overflow")
  `LTSM_ASSERT(a_file_reset, (take && cmd_i.last) |=> (line_q == LineW'(1) && !abort_q),
               "file state not reset after last byte")

endmodule

FILE: sv/line_text_search_matcher_unit.sv
// top level of the streaming per-line pattern search
//
// input side is a queue: drive in_item_i and raise push; the request is taken
// on a clock edge where push is high and full is low. results come out of a
// second queue: while empty is low the oldest result sits on out_item_o and
// is taken on an edge where pop is high.
// a pushed request waits in the request queue; its result (if any) is
// registered in the result queue. throughput is one byte per cycle, set by the
// single window compare in the back part, as long as results are popped.
// a two entry request queue sits between the classifier and the matcher and
// a two entry result queue sits at the output; when the receiver stops
// popping, the matcher keeps taking bytes until the result queue fills, then
// the request queue fills and full rises.
// configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user
// writes it only while no request is in flight, and the block itself does not enforce this.
// reset (rst_ni low, asynchronous) clears both queues, the pattern
// registers and all line and file state; line numbering restarts at one.
`include "assert_macros.svh"

module line_text_search_matcher_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  ltsm_pkg::in_item_t                  in_item_i,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output ltsm_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [ltsm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ltsm_pkg::CfgDataW-1:0]       cfg_data_i
);
  import ltsm_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd, queue_cmd;
  logic cmd_valid, cmd_pop;

  // register decode, unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_FIRST:  cfg_d.pat_first  = cfg_data_i;
        CFG_PAT_SECOND: cfg_d.pat_second = cfg_data_i;
        CFG_PAT_LEN:    cfg_d.pat_len    = cfg_data_i[LenW-1:0];
        CFG_CASE_SENS:  cfg_d.case_sens  = cfg_data_i[0];
        CFG_WHOLE_WORD: cfg_d.whole_word = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify each byte as it arrives
  ltsm_front u_front (
    .item_i      (in_item_i),
    .case_sens_i (cfg_q.case_sens),
    .cmd_o       (front_cmd)
  );

  // decouples the classifier from the matcher
  ltsm_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (cmd_pop)
  );

  // window compare, line bookkeeping and result queue
  ltsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (out_item_o)
  );

  `LTSM_NEVER(a_pop_idle, cmd_pop && !cmd_valid, "matcher took a request from an empty queue")
  `LTSM_ASSERT(a_len_written, (cfg_we_i && cfg_idx_i == CFG_PAT_LEN)
               |=> (cfg_q.pat_len == $past(cfg_data_i[LenW-1:0])), "length register not taken")
  `LTSM_ASSERT(a_cfg_hold, !cfg_we_i |=> $stable(cfg_q), "configuration changed without a write")

endmodule

FILE: bench/tb_line_text_search_matcher_unit.sv
// self-checking bench of the streaming line search: predicts reported lines and checks each result
`timescale 1ns / 1ps

module tb_line_text_search_matcher_unit;
  import ltsm_pkg::*;

  localparam int MAX_PAT     = MaxPattern;
  localparam int WIN         = WinDepth;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 8;

  localparam bit [7:0] TAB    = 8'h09;
  localparam bit [7:0] LF     = 8'h0A;
  localparam bit [7:0] CR     = 8'h0D;
  localparam bit [7:0] EOF_CH = 8'h1A;
  localparam bit [7:0] ESC    = 8'h1B;

  // predictor of reported lines, with its own copy of the registers
  class line_hit_scoreboard;
    bit [63:0] pat_lo, pat_hi;
    bit [4:0]  pat_len;
    bit        exact_case, whole_word;
    bit [7:0]  window [WIN];
    int unsigned fill, skip;
    bit        cand, line_hit, file_hit, aborted;
    bit [31:0] line_no;
    out_item_t expected_reports[$];
    int        errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      exact_case = 1'b0;
      whole_word = 1'b0;
      errors = 0;
      clear_file();
    endfunction

    function void set_reg(cfg_idx_e idx, bit [63:0] v);
      case (idx)
        CFG_PAT_FIRST:  pat_lo = v;
        CFG_PAT_SECOND: pat_hi = v;
        CFG_PAT_LEN:    pat_len = v[4:0];
        CFG_CASE_SENS:  exact_case = v[0];
        CFG_WHOLE_WORD: whole_word = v[0];
        default: ;
      endcase
    endfunction

    function bit is_letter(bit [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    // word edges: blanks and every printable that is not a letter, digit or underscore
    function bit word_break(bit [7:0] b);
      if (b == TAB || b == LF || b == CR || b == 8'h20) return 1'b1;
      if (b < 8'h21 || b > 8'h7E) return 1'b0;
      return !(is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == 8'h5F);
    endfunction

    function bit is_control(bit [7:0] b);
      return b < 8'h20 && !(b >= 8'h07 && b <= CR) && b != EOF_CH;
    endfunction

    function bit [7:0] upcase(bit [7:0] b);
      if (!exact_case && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
      return b;
    endfunction

    function bit [7:0] pat_byte(int i);
      if (i < 8) return pat_lo[8*i +: 8];
      if (i < 16) return pat_hi[8*(i-8) +: 8];
      return 8'h00;
    endfunction

    function void clear_line();
      foreach (window[k]) window[k] = 8'h00;
      fill = 0;
      skip = 0;
      cand = 1'b0;
      line_hit = 1'b0;
    endfunction

    function void clear_file();
      clear_line();
      file_hit = 1'b0;
      line_no = 32'd1;
      aborted = 1'b0;
    endfunction

    function void report(bit lm, bit done, bit bin, bit fm);
      expected_reports.push_back(out_item_t'{line_number: line_no, line_matched: lm,
                                             file_done: done, binary_abort: bin,
                                             file_matched: fm});
    endfunction

    // one kept byte of the line: window shift and compare at the newest position
    function void shift_in(bit [7:0] b);
      int unsigned n;
      int k;
      bit hit;
      n = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
      if (cand) begin
        cand = 1'b0;
        if (word_break(b)) line_hit = 1'b1;
      end
      for (k = WIN - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (fill < WIN) fill++;
      if (n == 0) return;
      if (skip > 0) begin
        skip--;
        return;
      end
      if (fill < n) return;
      hit = 1'b1;
      for (k = 0; k < n; k++)
        if (upcase(window[n-1-k]) != upcase(pat_byte(k))) hit = 1'b0;
      if (!hit) return;
      // found occurrence blocks the next n-1 start positions, accepted or not
      skip = n - 1;
      if (!whole_word) line_hit = 1'b1;
      else if (fill == n || word_break(window[n])) cand = 1'b1;
    endfunction

    function void note_request(in_item_t it);
      bit [7:0] b;
      bit matched;
      b = it.text_byte;
      if (aborted) begin
        if (it.last_of_file) clear_file();
        return;
      end
      if (is_control(b)) begin
        report(1'b0, 1'b1, 1'b1, file_hit);
        if (it.last_of_file) clear_file();
        else begin
          clear_line();
          aborted = 1'b1;
        end
        return;
      end
      if (b != LF && b != CR) shift_in(b);
      if (b != LF && !it.last_of_file) return;
      // line end always passes a pending word edge test
      if (cand) line_hit = 1'b1;
      matched = line_hit;
      if (matched) file_hit = 1'b1;
      if (it.last_of_file) begin
        report(matched, 1'b1, 1'b0, file_hit);
        clear_file();
        return;
      end
      if (matched) report(1'b1, 1'b0, 1'b0, 1'b1);
      if (line_no != 32'hFFFF_FFFF) line_no++;
      clear_line();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result line %0d lm %b done %b bin %b fm %b", $time,
                 got.line_number, got.line_matched, got.file_done, got.binary_abort,
                 got.file_matched);
        return;
      end
      want = expected_reports.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected line %0d lm %b done %b bin %b fm %b", $time,
                 want.line_number, want.line_matched, want.file_done, want.binary_abort,
                 want.file_matched);
        $display("%0t:          actual   line %0d lm %b done %b bin %b fm %b", $time,
                 got.line_number, got.line_matched, got.file_done, got.binary_abort,
                 got.file_matched);
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  in_item_t            in_item_i;
  logic                full;
  logic                empty;
  logic                pop;
  out_item_t           out_item_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  line_text_search_matcher_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  line_hit_scoreboard sb = new();
  in_item_t  stim_bytes[$];
  bit [7:0]  pat_b [MAX_PAT];
  int        gen_len;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: pop pattern rotates through free run, coin flip,
  // one in eight and a 10-of-16 burst
  initial begin
    int cyc;
    cyc = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_item_o);
      cyc++;
      case ((cyc / 40) % 4)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= (cyc % 8 == 0);
        default: pop <= (cyc % 16 < 10);
      endcase
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || cfg_we_i) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function void put(bit [7:0] b, bit last);
    stim_bytes.push_back(in_item_t'{text_byte: b, last_of_file: last});
  endfunction

  function void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endfunction

  function bit [7:0] rand_letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  function bit [7:0] rand_pat_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return rand_letter();
    if (r < 15) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 17) return 8'($urandom_range(8'h21, 8'h2F));
    if (r == 17) return 8'h5F;
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  function bit [7:0] rand_sep();
    case ($urandom_range(0, 4))
      0:       return 8'h20;
      1:       return TAB;
      2:       return 8'($urandom_range(8'h21, 8'h2F));
      3:       return 8'($urandom_range(8'h3A, 8'h40));
      default: return 8'($urandom_range(8'h7B, 8'h7E));
    endcase
  endfunction

  // copy of the pattern, letters flipped in case now and then
  function void put_pattern(int n);
    bit [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = pat_b[i];
      if (sb.is_letter(b) && $urandom_range(0, 3) == 0) b ^= 8'h20;
      put(b, 1'b0);
    end
  endfunction

  // one file: mostly lines built around the pattern, sometimes raw noise
  function void add_file();
    int lines, toks;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 11)) put(8'($urandom_range(0, 255)), 1'b0);
      put(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    lines = $urandom_range(1, 4);
    for (int l = 0; l < lines; l++) begin
      toks = $urandom_range(1, 4);
      for (int t = 0; t < toks; t++) begin
        case ($urandom_range(0, 11))
          0, 1, 2: put_pattern(gen_len);
          3: begin
            put_pattern(gen_len);
            put_pattern(gen_len);
          end
          4:       put_pattern($urandom_range(1, gen_len));
          5, 6:    repeat ($urandom_range(1, 5)) put(rand_pat_byte(), 1'b0);
          7:       put(rand_sep(), 1'b0);
          8:       put(CR, 1'b0);
          9:       put(8'($urandom_range(0, 255)), 1'b0);
          default: put(rand_letter(), 1'b0);
        endcase
        if ($urandom_range(0, 1)) put(rand_sep(), 1'b0);
      end
      if (l < lines - 1) put(LF, 1'b0);
    end
    // closing byte of the file
    case ($urandom_range(0, 5))
      0:       put(LF, 1'b1);
      1:       put(CR, 1'b1);
      2:       put(rand_letter(), 1'b1);
      3:       put(8'h20, 1'b1);
      4:       put(8'($urandom_range(0, 6)), 1'b1);
      default: put(pat_b[gen_len-1], 1'b1);
    endcase
  endfunction

  // sender: bursts of random length, random gaps in between
  task automatic feed_stim();
    in_item_t it;
    int burst, gap;
    burst = $urandom_range(1, 24);
    while (stim_bytes.size() > 0) begin
      it = stim_bytes.pop_front();
      push <= 1'b1;
      in_item_i <= it;
      do @(posedge clk_i); while (full);
      sb.note_request(it);
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 24);
      end
    end
    push <= 1'b0;
  endtask

  // all results in, then a settling wait for requests that report nothing
  task automatic drain();
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_setting(bit [63:0] lo, bit [63:0] hi, bit [4:0] len, bit cs, bit ww);
    write_reg(CFG_PAT_FIRST, lo);
    write_reg(CFG_PAT_SECOND, hi);
    write_reg(CFG_PAT_LEN, 64'(len));
    write_reg(CFG_CASE_SENS, 64'(cs));
    write_reg(CFG_WHOLE_WORD, 64'(ww));
    cfg_we_i <= 1'b0;
    for (int i = 0; i < MAX_PAT; i++) pat_b[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    gen_len = (len == 0) ? 3 : ((len > MAX_PAT) ? MAX_PAT : len);
  endtask

  initial begin
    bit [63:0] lo, hi;
    bit [4:0]  len;
    bit        cs, ww;
    int        random_done, p;

    rst_ni <= 1'b0;
    push <= 1'b0;
    in_item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset setting, empty pattern: plain byte, then a control byte that also ends the file
    put(8'h61, 1'b0);
    put(8'h00, 1'b1);
    feed_stim();
    drain();

    // "ab", folded case, whole words, upper register all ones
    apply_setting(64'h0000_0000_0000_6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b0, 1'b1);
    put_str("AB");           // match at line start, CR dropped before newline
    put(CR, 1'b0);
    put(LF, 1'b0);
    put_str("xab,ab");       // glued candidate rejected, next one accepted at line end
    put(LF, 1'b0);
    put(8'hFF, 1'b0);
    put(ESC, 1'b0);          // control byte aborts, rest of the file ignored
    put_str("q");
    put(8'h7A, 1'b1);
    put_str("aab");          // rejected candidate, file closed by CR
    put(CR, 1'b1);
    feed_stim();

    random_done = 0;
    p = 0;
    while (random_done < RANDOM_ITEMS) begin
      drain();
      for (int i = 0; i < MAX_PAT; i++) pat_b[i] = rand_pat_byte();
      cs = 1'($urandom_range(0, 1));
      ww = 1'($urandom_range(0, 1));
      len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(7, 15)) : 5'($urandom_range(1, 6));
      case (p)
        0: begin
          len = 5'd1;
          cs = 1'b1;
          ww = 1'b0;
        end
        1: begin
          len = 5'd16;
          cs = 1'b0;
          ww = 1'b1;
        end
        2: begin
          len = 5'd31;           // clamped to the maximum length
          cs = 1'b1;
          ww = 1'b0;
        end
        3: begin
          len = 5'd0;            // nothing can match
          ww = 1'b1;
        end
        4: begin
          len = 5'd3;
          pat_b[1] = LF;         // pattern that can never be found
          ww = 1'b0;
        end
        default: ;
      endcase
      for (int i = 0; i < MAX_PAT; i++) begin
        if (i < 8) lo[8*i +: 8] = pat_b[i];
        else hi[8*(i-8) +: 8] = pat_b[i];
      end
      apply_setting(lo, hi, len, cs, ww);
      while (stim_bytes.size() < 30) add_file();
      random_done += stim_bytes.size();
      feed_stim();
      p++;
    end

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
